// File: design/hcpf_pkg.sv
package hcpf_pkg;

    localparam int POS_W   = 32;
    localparam int DIFF_W  = 33;
    localparam int RAD_W   = 31;
    localparam int SUM_W   = 32;
    localparam int DIST_W  = 32;
    localparam int ROOT2_W = 24;
    localparam int UNIT_W  = 31;
    localparam int STIFF_W = 20;
    localparam int FORCE_W = 48;

    localparam logic [STIFF_W-1:0] STIFF_RESET = 20'd10000;
    localparam logic [FORCE_W-1:0] SAT_MAG     = 48'h7FFF_FFFF_FFFF;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic contact;
        logic coincide;
    } hcpf_flags_t;

    // payload carried beside the distance root
    typedef struct packed {
        logic [SUM_W-1:0] ax;
        logic [SUM_W-1:0] ay;
        logic [SUM_W-1:0] rs;
        hcpf_flags_t      flags;
    } hcpf_dist_side_t;

    // payload carried beside the overlap root
    typedef struct packed {
        logic [SUM_W-1:0]  ax;
        logic [SUM_W-1:0]  ay;
        logic [DIST_W-1:0] d;
        logic [SUM_W-1:0]  s;
        hcpf_flags_t       flags;
    } hcpf_ovl_side_t;

    // payload carried beside the unit-vector dividers
    typedef struct packed {
        logic [SUM_W-1:0]   s;
        logic [ROOT2_W-1:0] sq;
        hcpf_flags_t        flags;
    } hcpf_div_side_t;

endpackage

// File: design/hcpf_front.sv
module hcpf_front (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    input  logic signed [hcpf_pkg::POS_W-1:0]         first_x,
    input  logic signed [hcpf_pkg::POS_W-1:0]         first_y,
    input  logic signed [hcpf_pkg::POS_W-1:0]         second_x,
    input  logic signed [hcpf_pkg::POS_W-1:0]         second_y,
    input  logic        [hcpf_pkg::RAD_W-1:0]         first_radius,
    input  logic        [hcpf_pkg::RAD_W-1:0]         second_radius,
    output logic                                      out_valid,
    output logic        [2*hcpf_pkg::DIST_W-1:0]      out_d2,
    output hcpf_pkg::hcpf_dist_side_t                 out_side
);

    localparam int DW = hcpf_pkg::DIFF_W;
    localparam int SW = hcpf_pkg::SUM_W;

    logic [3:0]              valid_reg;

    logic signed [DW-1:0]    dx_reg;
    logic signed [DW-1:0]    dy_reg;
    logic [SW-1:0]           rs1_reg;

    logic [DW-1:0]           ax_reg;
    logic [DW-1:0]           ay_reg;
    logic                    negx2_reg;
    logic                    negy2_reg;
    logic [SW-1:0]           rs2_reg;

    logic [2*DW-1:0]         dx2_reg;
    logic [2*DW-1:0]         dy2_reg;
    logic [2*SW-1:0]         rsq_reg;
    logic [DW-1:0]           ax3_reg;
    logic [DW-1:0]           ay3_reg;
    logic                    negx3_reg;
    logic                    negy3_reg;
    logic [SW-1:0]           rs3_reg;

    logic [2*SW-1:0]         d2_reg;
    hcpf_pkg::hcpf_dist_side_t side_reg;

    logic [2*DW:0]           d2_sum;
    logic                    overlap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    // stage 1: separation and radius sum
    always_ff @(posedge clk)
    begin
        dx_reg  <= {second_x[hcpf_pkg::POS_W-1], second_x}
                 - {first_x[hcpf_pkg::POS_W-1], first_x};
        dy_reg  <= {second_y[hcpf_pkg::POS_W-1], second_y}
                 - {first_y[hcpf_pkg::POS_W-1], first_y};
        rs1_reg <= {1'b0, first_radius} + {1'b0, second_radius};
    end

    // stage 2: magnitudes
    always_ff @(posedge clk)
    begin
        ax_reg    <= dx_reg[DW-1] ? DW'(-dx_reg) : DW'(dx_reg);
        ay_reg    <= dy_reg[DW-1] ? DW'(-dy_reg) : DW'(dy_reg);
        negx2_reg <= dx_reg[DW-1];
        negy2_reg <= dy_reg[DW-1];
        rs2_reg   <= rs1_reg;
    end

    // stage 3: squares
    always_ff @(posedge clk)
    begin
        dx2_reg   <= ax_reg * ax_reg;
        dy2_reg   <= ay_reg * ay_reg;
        rsq_reg   <= rs2_reg * rs2_reg;
        ax3_reg   <= ax_reg;
        ay3_reg   <= ay_reg;
        negx3_reg <= negx2_reg;
        negy3_reg <= negy2_reg;
        rs3_reg   <= rs2_reg;
    end

    // stage 4: exact contact test
    assign d2_sum  = {1'b0, dx2_reg} + {1'b0, dy2_reg};
    assign overlap = d2_sum < {{(2*DW+1-2*SW){1'b0}}, rsq_reg};

    always_ff @(posedge clk)
    begin
        d2_reg                  <= d2_sum[2*SW-1:0];
        side_reg.ax             <= ax3_reg[SW-1:0];
        side_reg.ay             <= ay3_reg[SW-1:0];
        side_reg.rs             <= rs3_reg;
        side_reg.flags.neg_x    <= negx3_reg;
        side_reg.flags.neg_y    <= negy3_reg;
        side_reg.flags.contact  <= overlap && (d2_sum != '0);
        side_reg.flags.coincide <= overlap && (d2_sum == '0);
    end

    assign out_valid = valid_reg[3];
    assign out_d2    = d2_reg;
    assign out_side  = side_reg;

endmodule

// File: design/hcpf_isqrt.sv
module hcpf_isqrt #(
    parameter int OUT_W  = 32,
    parameter int SIDE_W = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [2*OUT_W-1:0]    in_value,
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    output logic [OUT_W-1:0]      out_root,
    output logic [SIDE_W-1:0]     out_side
);

    localparam int IN_W  = 2 * OUT_W;
    localparam int REM_W = OUT_W + 2;

    logic [OUT_W-1:0]  valid_reg;
    logic [IN_W-1:0]   val_reg  [OUT_W];
    logic [REM_W-1:0]  rem_reg  [OUT_W];
    logic [OUT_W-1:0]  root_reg [OUT_W];
    logic [SIDE_W-1:0] side_reg [OUT_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[OUT_W-2:0], in_valid};
        end
    end

    // one result bit per stage
    for (genvar i = 0; i < OUT_W; i++)
    begin : g_stage
        logic [IN_W-1:0]   val_prev;
        logic [REM_W-1:0]  rem_prev;
        logic [OUT_W-1:0]  root_prev;
        logic [SIDE_W-1:0] side_prev;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic              ge;

        if (i == 0)
        begin : g_first
            assign val_prev  = in_value;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign side_prev = in_side;
        end
        else
        begin : g_next
            assign val_prev  = val_reg[i-1];
            assign rem_prev  = rem_reg[i-1];
            assign root_prev = root_reg[i-1];
            assign side_prev = side_reg[i-1];
        end

        assign rem_sh = {rem_prev[OUT_W-1:0], val_prev[IN_W-1 -: 2]};
        assign trial  = {root_prev, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge clk)
        begin
            val_reg[i]  <= {val_prev[IN_W-3:0], 2'b00};
            rem_reg[i]  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg[i] <= {root_prev[OUT_W-2:0], ge};
            side_reg[i] <= side_prev;
        end
    end

    assign out_valid = valid_reg[OUT_W-1];
    assign out_root  = root_reg[OUT_W-1];
    assign out_side  = side_reg[OUT_W-1];

endmodule

// File: design/hcpf_div.sv
// Two lanes of floor((num << (Q_W-1)) / den), num <= den, den >= 1.
module hcpf_div #(
    parameter int DEN_W  = 32,
    parameter int Q_W    = 31,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [DEN_W-1:0]  num_a,
    input  logic [DEN_W-1:0]  num_b,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [Q_W-1:0]    quo_a,
    output logic [Q_W-1:0]    quo_b,
    output logic [SIDE_W-1:0] out_side
);

    localparam int REM_W = DEN_W + 1;

    logic [Q_W-1:0]    valid_reg;
    logic [DEN_W-1:0]  den_reg   [Q_W];
    logic [DEN_W-1:0]  rema_reg  [Q_W];
    logic [DEN_W-1:0]  remb_reg  [Q_W];
    logic [Q_W-1:0]    bitsa_reg [Q_W];
    logic [Q_W-1:0]    bitsb_reg [Q_W];
    logic [Q_W-1:0]    qa_reg    [Q_W];
    logic [Q_W-1:0]    qb_reg    [Q_W];
    logic [SIDE_W-1:0] side_reg  [Q_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[Q_W-2:0], in_valid};
        end
    end

    // one quotient bit per stage in each lane
    for (genvar i = 0; i < Q_W; i++)
    begin : g_stage
        logic [DEN_W-1:0]  den_prev;
        logic [DEN_W-1:0]  rema_prev;
        logic [DEN_W-1:0]  remb_prev;
        logic [Q_W-1:0]    bitsa_prev;
        logic [Q_W-1:0]    bitsb_prev;
        logic [Q_W-1:0]    qa_prev;
        logic [Q_W-1:0]    qb_prev;
        logic [SIDE_W-1:0] side_prev;
        logic [REM_W-1:0]  rema_sh;
        logic [REM_W-1:0]  remb_sh;
        logic              ge_a;
        logic              ge_b;
        logic [REM_W-1:0]  rema_sub;
        logic [REM_W-1:0]  remb_sub;

        if (i == 0)
        begin : g_first
            assign den_prev   = den;
            assign rema_prev  = {1'b0, num_a[DEN_W-1:1]};
            assign remb_prev  = {1'b0, num_b[DEN_W-1:1]};
            assign bitsa_prev = {num_a[0], {(Q_W-1){1'b0}}};
            assign bitsb_prev = {num_b[0], {(Q_W-1){1'b0}}};
            assign qa_prev    = '0;
            assign qb_prev    = '0;
            assign side_prev  = in_side;
        end
        else
        begin : g_next
            assign den_prev   = den_reg[i-1];
            assign rema_prev  = rema_reg[i-1];
            assign remb_prev  = remb_reg[i-1];
            assign bitsa_prev = bitsa_reg[i-1];
            assign bitsb_prev = bitsb_reg[i-1];
            assign qa_prev    = qa_reg[i-1];
            assign qb_prev    = qb_reg[i-1];
            assign side_prev  = side_reg[i-1];
        end

        assign rema_sh  = {rema_prev, bitsa_prev[Q_W-1]};
        assign remb_sh  = {remb_prev, bitsb_prev[Q_W-1]};
        assign ge_a     = rema_sh >= {1'b0, den_prev};
        assign ge_b     = remb_sh >= {1'b0, den_prev};
        assign rema_sub = rema_sh - {1'b0, den_prev};
        assign remb_sub = remb_sh - {1'b0, den_prev};

        always_ff @(posedge clk)
        begin
            den_reg[i]   <= den_prev;
            rema_reg[i]  <= ge_a ? rema_sub[DEN_W-1:0] : rema_sh[DEN_W-1:0];
            remb_reg[i]  <= ge_b ? remb_sub[DEN_W-1:0] : remb_sh[DEN_W-1:0];
            bitsa_reg[i] <= {bitsa_prev[Q_W-2:0], 1'b0};
            bitsb_reg[i] <= {bitsb_prev[Q_W-2:0], 1'b0};
            qa_reg[i]    <= {qa_prev[Q_W-2:0], ge_a};
            qb_reg[i]    <= {qb_prev[Q_W-2:0], ge_b};
            side_reg[i]  <= side_prev;
        end
    end

    assign out_valid = valid_reg[Q_W-1];
    assign quo_a     = qa_reg[Q_W-1];
    assign quo_b     = qb_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];

endmodule

// File: design/hcpf_force.sv
module hcpf_force (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic [hcpf_pkg::SUM_W-1:0]            s,
    input  logic [hcpf_pkg::ROOT2_W-1:0]          sq,
    input  logic [hcpf_pkg::UNIT_W-1:0]           ux,
    input  logic [hcpf_pkg::UNIT_W-1:0]           uy,
    input  hcpf_pkg::hcpf_flags_t                 flags,
    input  logic [hcpf_pkg::STIFF_W-1:0]          stiffness,
    output logic                                  done,
    output logic signed [hcpf_pkg::FORCE_W-1:0]   force_x,
    output logic signed [hcpf_pkg::FORCE_W-1:0]   force_y,
    output logic                                  in_contact,
    output logic                                  error_flag
);

    localparam int SW    = hcpf_pkg::SUM_W;
    localparam int QW    = hcpf_pkg::ROOT2_W;
    localparam int UW    = hcpf_pkg::UNIT_W;
    localparam int KW    = hcpf_pkg::STIFF_W;
    localparam int FW    = hcpf_pkg::FORCE_W;
    localparam int PP_W  = SW + QW;          // s * sqrt(s)
    localparam int P_W   = PP_W - 16;        // s^1.5 from the Q.8 product, 16 bits dropped
    localparam int PH_W  = P_W - KW;
    localparam int F_W   = P_W + KW;         // stiffness * s^1.5
    localparam int FH_W  = F_W - 30;
    localparam int XH_W  = FH_W + UW;
    localparam int XL_W  = 30 + UW;
    localparam int MAG_W = XH_W + 1;

    logic [4:0]             valid_reg;

    logic [PP_W-1:0]        pp_reg;
    logic [UW-1:0]          ux1_reg, uy1_reg;
    hcpf_pkg::hcpf_flags_t  fl1_reg;

    logic [PH_W+KW-1:0]     kh_reg;
    logic [2*KW-1:0]        kl_reg;
    logic [UW-1:0]          ux2_reg, uy2_reg;
    hcpf_pkg::hcpf_flags_t  fl2_reg;

    logic [F_W-1:0]         f_reg;
    logic [UW-1:0]          ux3_reg, uy3_reg;
    hcpf_pkg::hcpf_flags_t  fl3_reg;

    logic [XH_W-1:0]        xh_reg, yh_reg;
    logic [XL_W-1:0]        xl_reg, yl_reg;
    hcpf_pkg::hcpf_flags_t  fl4_reg;

    logic signed [FW-1:0]   fx_reg, fy_reg;
    logic                   contact_reg;
    logic                   err_reg;

    logic [P_W-1:0]         p_val;
    logic [F_W:0]           f_sum;
    logic [MAG_W-1:0]       mag_x, mag_y;
    logic                   sat_x, sat_y;
    logic [FW-1:0]          lim_x, lim_y;
    logic [FW-1:0]          fx_next, fy_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    // stage 1: s * sqrt(s)
    always_ff @(posedge clk)
    begin
        pp_reg  <= s * sq;
        ux1_reg <= ux;
        uy1_reg <= uy;
        fl1_reg <= flags;
    end

    // stage 2: stiffness times both halves of s^1.5
    assign p_val = pp_reg[PP_W-1:16];

    always_ff @(posedge clk)
    begin
        kh_reg  <= p_val[P_W-1:KW] * stiffness;
        kl_reg  <= p_val[KW-1:0] * stiffness;
        ux2_reg <= ux1_reg;
        uy2_reg <= uy1_reg;
        fl2_reg <= fl1_reg;
    end

    // stage 3: join the halves
    assign f_sum = {1'b0, kh_reg, {KW{1'b0}}} + {{(F_W+1-2*KW){1'b0}}, kl_reg};

    always_ff @(posedge clk)
    begin
        f_reg   <= f_sum[F_W-1:0];
        ux3_reg <= ux2_reg;
        uy3_reg <= uy2_reg;
        fl3_reg <= fl2_reg;
    end

    // stage 4: split products against the unit vector
    always_ff @(posedge clk)
    begin
        xh_reg  <= f_reg[F_W-1:30] * ux3_reg;
        xl_reg  <= f_reg[29:0] * ux3_reg;
        yh_reg  <= f_reg[F_W-1:30] * uy3_reg;
        yl_reg  <= f_reg[29:0] * uy3_reg;
        fl4_reg <= fl3_reg;
    end

    // stage 5: combine, clamp, apply sign
    assign mag_x = {1'b0, xh_reg} + {{(MAG_W-(XL_W-30)){1'b0}}, xl_reg[XL_W-1:30]};
    assign mag_y = {1'b0, yh_reg} + {{(MAG_W-(XL_W-30)){1'b0}}, yl_reg[XL_W-1:30]};
    assign sat_x = mag_x > {{(MAG_W-FW){1'b0}}, hcpf_pkg::SAT_MAG};
    assign sat_y = mag_y > {{(MAG_W-FW){1'b0}}, hcpf_pkg::SAT_MAG};
    assign lim_x = sat_x ? hcpf_pkg::SAT_MAG : mag_x[FW-1:0];
    assign lim_y = sat_y ? hcpf_pkg::SAT_MAG : mag_y[FW-1:0];

    always_comb
    begin
        fx_next = '0;
        fy_next = '0;
        if (fl4_reg.contact)
        begin
            fx_next = fl4_reg.neg_x ? (FW'(0) - lim_x) : lim_x;
            fy_next = fl4_reg.neg_y ? (FW'(0) - lim_y) : lim_y;
        end
    end

    always_ff @(posedge clk)
    begin
        fx_reg      <= fx_next;
        fy_reg      <= fy_next;
        contact_reg <= fl4_reg.contact;
        err_reg     <= fl4_reg.coincide || (fl4_reg.contact && (sat_x || sat_y));
    end

    assign done       = valid_reg[4];
    assign force_x    = fx_reg;
    assign force_y    = fy_reg;
    assign in_contact = contact_reg;
    assign error_flag = err_reg;

endmodule

// File: design/hertz_contact_pair_force.sv
// Channel   Direction  Handshake                 Word
// -------   ---------  ------------------------  ---------------------------------------
// pair      in         start & !busy             first_x/y, second_x/y, first/second_radius
// result    out        done (one-cycle strobe)   force_x, force_y, in_contact, error_flag
// config    in         cfg_valid & cfg_ready     cfg_data (stiffness)
//
// One pair enters per clock; each result follows its pair through the
// bit-per-stage units: distance root (32 stages), overlap root (24),
// unit-vector dividers (31), plus 10 arithmetic stages.
// busy and cfg_ready are constant; the result side has no backpressure.
// Reset clears all stage valid bits and loads stiffness to its default.
module hertz_contact_pair_force #(
    parameter logic [hcpf_pkg::STIFF_W-1:0] STIFF_RESET = hcpf_pkg::STIFF_RESET
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [hcpf_pkg::POS_W-1:0]     first_x,
    input  logic signed [hcpf_pkg::POS_W-1:0]     first_y,
    input  logic signed [hcpf_pkg::POS_W-1:0]     second_x,
    input  logic signed [hcpf_pkg::POS_W-1:0]     second_y,
    input  logic        [hcpf_pkg::RAD_W-1:0]     first_radius,
    input  logic        [hcpf_pkg::RAD_W-1:0]     second_radius,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic        [hcpf_pkg::STIFF_W-1:0]   cfg_data,
    output logic                                  done,
    output logic signed [hcpf_pkg::FORCE_W-1:0]   force_x,
    output logic signed [hcpf_pkg::FORCE_W-1:0]   force_y,
    output logic                                  in_contact,
    output logic                                  error_flag
);

    localparam int DW = hcpf_pkg::DIST_W;
    localparam int SW = hcpf_pkg::SUM_W;

    logic [hcpf_pkg::STIFF_W-1:0] stiffness_reg;

    // front end -> distance root
    logic                          fr_valid;
    logic [2*DW-1:0]               fr_d2;
    hcpf_pkg::hcpf_dist_side_t     fr_side;

    // distance root -> overlap stage
    logic                          r1_valid;
    logic [DW-1:0]                 r1_d;
    hcpf_pkg::hcpf_dist_side_t     r1_side;

    // overlap stage register
    logic                          ov_valid_reg;
    hcpf_pkg::hcpf_ovl_side_t      ov_side_reg;
    logic [SW-1:0]                 s_next;

    // overlap root -> dividers
    logic                          r2_valid;
    logic [hcpf_pkg::ROOT2_W-1:0]  r2_sq;
    hcpf_pkg::hcpf_ovl_side_t      r2_side;
    hcpf_pkg::hcpf_div_side_t      dv_in_side;

    // dividers -> force stages
    logic                          dv_valid;
    logic [hcpf_pkg::UNIT_W-1:0]   dv_ux;
    logic [hcpf_pkg::UNIT_W-1:0]   dv_uy;
    hcpf_pkg::hcpf_div_side_t      dv_side;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // hold stiffness between writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiffness_reg <= STIFF_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            stiffness_reg <= cfg_data;
        end
    end

    // separation, squares and the exact contact test
    hcpf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (start && !busy),
        .first_x       (first_x),
        .first_y       (first_y),
        .second_x      (second_x),
        .second_y      (second_y),
        .first_radius  (first_radius),
        .second_radius (second_radius),
        .out_valid     (fr_valid),
        .out_d2        (fr_d2),
        .out_side      (fr_side)
    );

    // distance d = floor(sqrt(dx^2 + dy^2))
    hcpf_isqrt #(
        .OUT_W  (DW),
        .SIDE_W ($bits(hcpf_pkg::hcpf_dist_side_t))
    ) u_dist_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_value  (fr_d2),
        .in_side   (fr_side),
        .out_valid (r1_valid),
        .out_root  (r1_d),
        .out_side  (r1_side)
    );

    // overlap s = r1 + r2 - d; only meaningful while in contact
    assign s_next = r1_side.rs - r1_d;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_valid_reg <= 1'b0;
        end
        else
        begin
            ov_valid_reg <= r1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        ov_side_reg.ax    <= r1_side.ax;
        ov_side_reg.ay    <= r1_side.ay;
        ov_side_reg.d     <= r1_d;
        ov_side_reg.s     <= s_next;
        ov_side_reg.flags <= r1_side.flags;
    end

    // sqrt(s) in Q.8: root of s scaled up by 2^16
    hcpf_isqrt #(
        .OUT_W  (hcpf_pkg::ROOT2_W),
        .SIDE_W ($bits(hcpf_pkg::hcpf_ovl_side_t))
    ) u_ovl_root (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ov_valid_reg),
        .in_value  ({ov_side_reg.s, 16'h0000}),
        .in_side   (ov_side_reg),
        .out_valid (r2_valid),
        .out_root  (r2_sq),
        .out_side  (r2_side)
    );

    assign dv_in_side.s     = r2_side.s;
    assign dv_in_side.sq    = r2_sq;
    assign dv_in_side.flags = r2_side.flags;

    // unit vector components |dx| * 2^30 / d, |dy| * 2^30 / d
    hcpf_div #(
        .DEN_W  (DW),
        .Q_W    (hcpf_pkg::UNIT_W),
        .SIDE_W ($bits(hcpf_pkg::hcpf_div_side_t))
    ) u_unit_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (r2_valid),
        .num_a     (r2_side.ax),
        .num_b     (r2_side.ay),
        .den       (r2_side.d),
        .in_side   (dv_in_side),
        .out_valid (dv_valid),
        .quo_a     (dv_ux),
        .quo_b     (dv_uy),
        .out_side  (dv_side)
    );

    // magnitude, projection, clamp and sign
    hcpf_force u_force (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (dv_valid),
        .s          (dv_side.s),
        .sq         (dv_side.sq),
        .ux         (dv_ux),
        .uy         (dv_uy),
        .flags      (dv_side.flags),
        .stiffness  (stiffness_reg),
        .done       (done),
        .force_x    (force_x),
        .force_y    (force_y),
        .in_contact (in_contact),
        .error_flag (error_flag)
    );

    // no contact means no force
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !in_contact) |-> (force_x == '0 && force_y == '0))
    else $error("force without contact");

    // clamping keeps the negation representable
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (force_x != {1'b1, {(hcpf_pkg::FORCE_W-1){1'b0}}}
               && force_y != {1'b1, {(hcpf_pkg::FORCE_W-1){1'b0}}}))
    else $error("force component reached the most negative code");

    // an error while in contact means some component sits at the clamp
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && in_contact && error_flag)
        |-> (force_x == $signed(hcpf_pkg::SAT_MAG)
          || force_x == -$signed(hcpf_pkg::SAT_MAG)
          || force_y == $signed(hcpf_pkg::SAT_MAG)
          || force_y == -$signed(hcpf_pkg::SAT_MAG)))
    else $error("error flag in contact without a clamped force");

endmodule
